@@ design/lef3_pkg.sv @@
package lef3_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 11'd480;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       drain;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_out_item;

endpackage

@@ design/laplacian_edge_filter_3x3_core.sv @@
// 3x3 eight-neighbor laplacian edge filter for a raster rgb pixel stream. Each accepted
// request is one pixel (or a drain filler that acts as a black pixel); every interior
// pixel comes out as 8*center minus its eight neighbors per channel, clamped to 0..255,
// and border pixels pass through unchanged. A pixel's result leaves image_width+1
// requests after it, so after the last pixel of a frame the source sends image_width+1
// drain requests to flush it; frame_end marks the result of the frame's last pixel and
// the position then restarts at zero. The block takes one request per clock unless the
// input stall is high: a request is accepted into a single processing stage while its
// line store reads are registered, and the stage hands its result to the output register
// when it moves on. Input stall rises only while the output register holds a result
// the consumer is stalling. The two line stores are single-write, single-read memories
// of MAX_WIDTH entries, read at the accept edge and written when the stage moves on; a
// same-address read in the next request is covered by a forwarding register.
// Dimensions outside 3..MAX are clamped when used.
module laplacian_edge_filter_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input requests
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lef3_pkg::t_in_item             i_in_data,
    // result requests
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lef3_pkg::t_out_item            o_out_data,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [lef3_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lef3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);       // column index bits
    localparam int WW = $clog2(MAX_WIDTH + 1);   // clamped width value
    localparam int HW = $clog2(MAX_HEIGHT + 1);  // clamped height value
    localparam int RW = $clog2(MAX_HEIGHT + 3);  // row position, up to height+2

    // configuration
    logic [lef3_pkg::CFG_DATA_W-1:0] r_cfg_width;
    logic [lef3_pkg::CFG_DATA_W-1:0] r_cfg_height;
    logic [WW-1:0]                   w_w;
    logic [HW-1:0]                   w_h;

    // raster position of the next request
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    // position decode for the window center of the incoming request
    logic [WW-1:0] w_ox;
    logic [RW-1:0] w_oy;
    logic [WW-1:0] w_col_inc;
    logic [RW-1:0] w_row_inc;
    logic          w_have;
    logic          w_emit;
    logic          w_border;
    logic          w_last;

    // handshake
    logic w_accept;
    logic w_advance;

    // processing stage
    logic          r_s1_valid;
    logic [23:0]   r_s1_px;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_emit;
    logic          r_s1_border;
    logic          r_s1_last;

    // line stores with registered reads and a forwarding path
    logic [23:0] r_upper_mem [MAX_WIDTH];
    logic [23:0] r_mid_mem   [MAX_WIDTH];
    logic [23:0] r_rd_upper;
    logic [23:0] r_rd_mid;
    logic        r_fwd;
    logic [23:0] r_fwd_upper;
    logic [23:0] r_fwd_mid;
    logic [23:0] w_above;
    logic [23:0] w_mid;

    // 3x3 window, [row top..bottom][col left..right]
    logic [23:0] r_win [3][3];

    logic [23:0] w_lap;
    logic [23:0] w_pix;

    // output register
    logic                r_out_valid;
    lef3_pkg::t_out_item r_out_data;

    // clamp configured dimensions into the supported range
    always_comb begin
        if (r_cfg_width < 11'd3) begin
            w_w = WW'(32'd3);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_cfg_width);
        end
        if (r_cfg_height < 11'd3) begin
            w_h = HW'(32'd3);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            w_h = HW'(MAX_HEIGHT);
        end else begin
            w_h = HW'(r_cfg_height);
        end
    end

    // stage moves on when the output register is free or being taken
    assign w_advance  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // the window center lags the input by one row and one column
    always_comb begin
        if (r_col != '0) begin
            w_ox   = WW'(r_col) - WW'(32'd1);
            w_have = r_row >= RW'(32'd1);
            w_oy   = r_row - RW'(32'd1);
        end else begin
            w_ox   = w_w - WW'(32'd1);
            w_have = r_row >= RW'(32'd2);
            w_oy   = r_row - RW'(32'd2);
        end
        w_emit   = w_have && (w_ox < w_w) && (w_oy < RW'(w_h));
        w_border = (w_ox == '0) || (w_ox == w_w - WW'(32'd1)) ||
                   (w_oy == '0) || (w_oy == RW'(w_h) - RW'(32'd1));
        w_last   = (w_ox == w_w - WW'(32'd1)) && (w_oy == RW'(w_h) - RW'(32'd1));
    end

    // next raster position, restart after frame end or a runaway row count
    always_comb begin
        w_col_inc = WW'(r_col) + WW'(32'd1);
        w_row_inc = r_row + RW'(32'd1);
        if (w_col_inc >= w_w) begin
            n_col = '0;
            n_row = w_row_inc;
        end else begin
            n_col = CW'(w_col_inc);
            n_row = r_row;
        end
        if ((w_emit && w_last) || (n_row > RW'(w_h) + RW'(32'd1))) begin
            n_col = '0;
            n_row = '0;
        end
    end

    // line store column for the stage, forwarded when the previous request wrote it
    assign w_above = r_fwd ? r_fwd_upper : r_rd_upper;
    assign w_mid   = r_fwd ? r_fwd_mid   : r_rd_mid;

    // laplacian per channel over the window after this request's shift
    always_comb begin
        logic [10:0]        sum;
        logic signed [12:0] acc;
        w_lap = '0;
        for (int k = 0; k < 3; k++) begin
            sum = 11'(r_win[0][1][k*8 +: 8]) + 11'(r_win[0][2][k*8 +: 8]) +
                  11'(w_above[k*8 +: 8]) +
                  11'(r_win[1][1][k*8 +: 8]) + 11'(w_mid[k*8 +: 8]) +
                  11'(r_win[2][1][k*8 +: 8]) + 11'(r_win[2][2][k*8 +: 8]) +
                  11'(r_s1_px[k*8 +: 8]);
            acc = $signed({2'b00, r_win[1][2][k*8 +: 8], 3'b000}) - $signed({2'b00, sum});
            if (acc > 13'sd255) begin
                w_lap[k*8 +: 8] = 8'hff;
            end else if (acc < 13'sd0) begin
                w_lap[k*8 +: 8] = 8'h00;
            end else begin
                w_lap[k*8 +: 8] = acc[7:0];
            end
        end
    end

    // border pixels keep the center value
    assign w_pix = r_s1_border ? r_win[1][2] : w_lap;

    // line stores: read at accept, write as the stage retires
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_upper <= r_upper_mem[r_col];
            r_rd_mid   <= r_mid_mem[r_col];
        end
        if (w_advance) begin
            r_upper_mem[r_s1_col] <= w_mid;
            r_mid_mem[r_s1_col]   <= r_s1_px;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px     <= i_in_data.drain ? 24'd0 :
                           {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
            r_s1_col    <= r_col;
            r_s1_emit   <= w_emit;
            r_s1_border <= w_border;
            r_s1_last   <= w_last;
            r_fwd_upper <= w_mid;
            r_fwd_mid   <= r_s1_px;
        end
        if (w_advance) begin
            r_out_data.out_red   <= w_pix[23:16];
            r_out_data.out_green <= w_pix[15:8];
            r_out_data.out_blue  <= w_pix[7:0];
            r_out_data.frame_end <= r_s1_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= lef3_pkg::RESET_IMAGE_WIDTH;
            r_cfg_height <= lef3_pkg::RESET_IMAGE_HEIGHT;
            r_col        <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd        <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lef3_pkg::CFG_IMAGE_WIDTH: begin
                        r_cfg_width <= i_cfg_data;
                    end
                    lef3_pkg::CFG_IMAGE_HEIGHT: begin
                        r_cfg_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
                // same column as the retiring request: memory read is stale
                r_fwd <= r_s1_valid && (r_s1_col == r_col);
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_emit;
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= w_above;
                r_win[1][2] <= w_mid;
                r_win[2][2] <= r_s1_px;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a full stage that cannot retire holds off the source
    a_stall_when_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("stage blocked without input stall");

    // a retiring request with a result fills the output register
    a_emit_fills_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_s1_emit) |=> o_out_valid)
        else $error("result lost at output register");

    // the frame's last result restarts the raster position
    a_frame_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit && w_last) |=> (r_col == '0 && r_row == '0))
        else $error("position not restarted after frame end");

endmodule

@@ dv/laplacian_edge_filter_3x3_core_tb.sv @@
module laplacian_edge_filter_3x3_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int CFG_W         = lef3_pkg::CFG_DATA_W;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET   = 1250;
    localparam int PRESSURE_HOLD = 500;

    // running image of the filter: line stores, window, raster position, dimensions
    class laplace_tracker;
        bit [10:0]           width_reg;
        bit [10:0]           height_reg;
        bit [23:0]           upper_line [MAX_W];
        bit [23:0]           middle_line [MAX_W];
        bit [23:0]           win [3][3];    // [top..bottom][left..right]
        int                  col;
        int                  row;
        lef3_pkg::t_out_item pending_pixels [$];
        int                  good_pixels;
        int                  bad_pixels;
        int                  frames_done;

        function new();
            width_reg  = lef3_pkg::RESET_IMAGE_WIDTH;
            height_reg = lef3_pkg::RESET_IMAGE_HEIGHT;
            col        = 0;
            row        = 0;
        endfunction

        function int clamp_dim(int v, int maxv);
            if (v < 3) return 3;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function int eff_width();
            return clamp_dim(width_reg, MAX_W);
        endfunction

        function int eff_height();
            return clamp_dim(height_reg, MAX_H);
        endfunction

        function bit at_start();
            return col == 0 && row == 0;
        endfunction

        function void set_reg(logic [lef3_pkg::CFG_INDEX_W-1:0] idx,
                              logic [lef3_pkg::CFG_DATA_W-1:0] value);
            if (idx == lef3_pkg::CFG_IMAGE_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        // 8*center minus the eight neighbors of one channel, clamped to a byte
        function bit [7:0] laplace_chan(int sh);
            int acc;
            acc = 8 * int'(win[1][1][sh +: 8]);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (i != 1 || j != 1) acc -= int'(win[i][j][sh +: 8]);
                end
            end
            if (acc > 255) acc = 255;
            if (acc < 0) acc = 0;
            return acc[7:0];
        endfunction

        // one accepted request: shift it in and queue the result it releases, if any
        function void take_pixel(lef3_pkg::t_in_item it);
            int                  w;
            int                  h;
            int                  ox;
            int                  oy;
            bit                  emit;
            bit                  closes_frame;
            bit [23:0]           px;
            bit [23:0]           above;
            bit [23:0]           mid;
            lef3_pkg::t_out_item res;
            w     = eff_width();
            h     = eff_height();
            px    = it.drain ? 24'd0 : {it.in_red, it.in_green, it.in_blue};
            above = '0;
            mid   = '0;
            closes_frame = 1'b0;
            if (col < MAX_W) begin
                above            = upper_line[col];
                mid              = middle_line[col];
                upper_line[col]  = mid;
                middle_line[col] = px;
            end
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = above;
            win[1][2] = mid;
            win[2][2] = px;
            // window center sits one row and one column behind the input
            if (col >= 1) begin
                ox   = col - 1;
                oy   = row - 1;
                emit = row >= 1;
            end else begin
                ox   = w - 1;
                oy   = row - 2;
                emit = row >= 2;
            end
            if (emit && ox < w && oy < h) begin
                if (ox == 0 || ox == w - 1 || oy == 0 || oy == h - 1) begin
                    res.out_red   = win[1][1][23:16];
                    res.out_green = win[1][1][15:8];
                    res.out_blue  = win[1][1][7:0];
                end else begin
                    res.out_red   = laplace_chan(16);
                    res.out_green = laplace_chan(8);
                    res.out_blue  = laplace_chan(0);
                end
                closes_frame  = (ox == w - 1 && oy == h - 1);
                res.frame_end = closes_frame;
                pending_pixels.push_back(res);
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end
            if (closes_frame || row > h + 1) begin
                col = 0;
                row = 0;
            end
        endfunction

        function void report_bad(string what, lef3_pkg::t_out_item want,
                                 lef3_pkg::t_out_item got);
            if (bad_pixels < 10) begin
                $display("%s: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                         what, want.out_red, want.out_green, want.out_blue, want.frame_end,
                         got.out_red, got.out_green, got.out_blue, got.frame_end);
            end
            bad_pixels++;
        endfunction

        // one accepted result against the oldest queued one
        function void check_pixel(lef3_pkg::t_out_item got);
            lef3_pkg::t_out_item want;
            if (pending_pixels.size() == 0) begin
                report_bad("result with none queued", '0, got);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                got.out_blue !== want.out_blue || got.frame_end !== want.frame_end) begin
                report_bad("pixel mismatch", want, got);
            end else begin
                good_pixels++;
            end
            if (want.frame_end) frames_done++;
        endfunction
    endclass

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    lef3_pkg::t_in_item               in_data   = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    lef3_pkg::t_out_item              out_data;
    logic                             cfg_we    = 1'b0;
    logic [lef3_pkg::CFG_INDEX_W-1:0] cfg_index = lef3_pkg::CFG_IMAGE_WIDTH;
    logic [lef3_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    laplace_tracker tracker = new();

    int cycle_count   = 0;
    int sent_items    = 0;
    int dim_settings  = 0;
    bit sender_gaps   = 1'b1;
    bit pressure_done = 1'b0;

    laplacian_edge_filter_3x3_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog on the whole run
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("[laplacian_edge_filter_3x3_core] ERROR");
        $finish;
    end

    // result requests are taken at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) tracker.check_pixel(out_data);
    end

    // result-side stall: short random stalls, free-running stretches, a few long
    // holds, and once a long hold-off while the source keeps offering pixels
    initial begin : result_sink
        int hold_left;
        int free_left;
        int roll;
        hold_left = 0;
        free_left = 0;
        forever begin
            @(negedge clk);
            if (!pressure_done && in_valid &&
                tracker.good_pixels + tracker.bad_pixels >= 300) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (free_left > 0) begin
                out_stall <= 1'b0;
                free_left--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    free_left = $urandom_range(20, 120);
                    out_stall <= 1'b0;
                end else if (roll < 13) begin
                    hold_left = $urandom_range(8, 40);
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end
            end
        end
    end

    // idle length before a request: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic lef3_pkg::t_in_item make_px(logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b, logic drain);
        lef3_pkg::t_in_item it;
        it.in_red   = r;
        it.in_green = g;
        it.in_blue  = b;
        it.drain    = drain;
        return it;
    endfunction

    // mix of noise, smooth areas around a frame tone, and saturated values
    function automatic logic [7:0] pick_chan(int tone);
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 8'($urandom_range(0, 255));
        if (roll < 80) begin
            v = tone + int'($urandom_range(0, 40)) - 20;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return v[7:0];
        end
        return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endfunction

    function automatic lef3_pkg::t_in_item random_px(int tone);
        return make_px(pick_chan(tone), pick_chan(tone), pick_chan(tone), 1'b0);
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_item(input lef3_pkg::t_in_item it);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        tracker.take_pixel(it);
        sent_items++;
    endtask

    // stop offering, let every queued result out, then let the pipe empty
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lef3_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lef3_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.set_reg(idx, value);
        dim_settings++;
    endtask

    task automatic write_dims(input int wv, input int hv);
        write_reg(lef3_pkg::CFG_IMAGE_WIDTH, wv[CFG_W-1:0]);
        write_reg(lef3_pkg::CFG_IMAGE_HEIGHT, hv[CFG_W-1:0]);
    endtask

    // new frame size at a frame boundary, mostly small, sometimes below the
    // legal minimum so the clamp kicks in
    task automatic new_small_dims();
        int roll;
        int wv;
        int hv;
        roll = $urandom_range(0, 99);
        wv   = (roll < 85) ? $urandom_range(3, 12) :
               (roll < 95) ? $urandom_range(13, 40) : $urandom_range(0, 2);
        roll = $urandom_range(0, 99);
        hv   = (roll < 85) ? $urandom_range(3, 8) :
               (roll < 95) ? $urandom_range(9, 16) : $urandom_range(0, 2);
        quiesce();
        write_dims(wv, hv);
    endtask

    // one frame of pixels plus its flush; the noisy form drops black drain
    // requests into the frame, pixels into the flush and bends the flush length
    task automatic send_frame(input bit noisy);
        int                 w;
        int                 h;
        int                 flush;
        int                 tone;
        int                 roll;
        lef3_pkg::t_in_item it;
        w     = tracker.eff_width();
        h     = tracker.eff_height();
        tone  = $urandom_range(0, 255);
        flush = w + 1;
        for (int k = 0; k < w * h; k++) begin
            it       = random_px(tone);
            it.drain = noisy && ($urandom_range(0, 99) < 4);
            send_item(it);
        end
        if (noisy) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) flush = $urandom_range(0, w);
            else if (roll < 30) flush = w + 1 + $urandom_range(1, 5);
        end
        for (int k = 0; k < flush; k++) begin
            it       = random_px(tone);
            it.drain = !(noisy && ($urandom_range(0, 99) < 6));
            send_item(it);
        end
    endtask

    // random requests until the position is back at the frame start
    task automatic finish_frame();
        lef3_pkg::t_in_item it;
        while (!tracker.at_start()) begin
            it       = random_px($urandom_range(0, 255));
            it.drain = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    // part of a frame, then a size change while the frame is open: height to
    // 0..8 (may fall below the current row), width to at most its current value
    task automatic send_broken_frame();
        int                 w;
        int                 n;
        lef3_pkg::t_in_item it;
        w = tracker.eff_width();
        n = $urandom_range(1, w * tracker.eff_height() + w);
        for (int k = 0; k < n; k++) begin
            it       = random_px($urandom_range(0, 255));
            it.drain = ($urandom_range(0, 99) < 5);
            send_item(it);
        end
        quiesce();
        if ($urandom_range(0, 1) != 0) begin
            write_reg(lef3_pkg::CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 8)));
        end else begin
            write_reg(lef3_pkg::CFG_IMAGE_WIDTH,
                      CFG_W'($urandom_range(0, tracker.eff_width())));
        end
        finish_frame();
    endtask

    // widest setting: all-ones width and zero height, clamped to the limits,
    // cut short by a width drop far below the current column
    task automatic run_wide_partial();
        finish_frame();
        quiesce();
        write_dims(2047, 0);
        for (int k = 0; k < 64; k++) send_item(random_px($urandom_range(0, 255)));
        quiesce();
        write_reg(lef3_pkg::CFG_IMAGE_WIDTH, CFG_W'(5));
        finish_frame();
        new_small_dims();
    endtask

    // tallest setting, cut short by a height drop far below the current row
    task automatic run_tall_partial();
        finish_frame();
        quiesce();
        write_dims(3, 2047);
        for (int k = 0; k < 120; k++) send_item(random_px($urandom_range(0, 255)));
        quiesce();
        write_reg(lef3_pkg::CFG_IMAGE_HEIGHT, CFG_W'(5));
        finish_frame();
        new_small_dims();
    endtask

    initial begin : stimulus
        int phase;
        int roll;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest frame, single interior pixel
        write_dims(3, 3);

        // bright center on black, one neighbor sent as a drain request with
        // color bits set: clamps high, drains leave no color behind
        for (int k = 0; k < 9; k++) begin
            if (k == 4) send_item(make_px(8'hFF, 8'hFF, 8'hFF, 1'b0));
            else if (k == 1) send_item(make_px(8'hA5, 8'h5A, 8'hC3, 1'b1));
            else send_item(make_px(8'h00, 8'h00, 8'h00, 1'b0));
        end
        for (int k = 0; k < 4; k++) send_item(make_px(8'hFF, 8'hFF, 8'hFF, 1'b1));

        // per-channel contrast: red clamps high, green clamps low, blue in range;
        // one flush slot carries a real pixel
        for (int k = 0; k < 9; k++) begin
            if (k == 4) send_item(make_px(8'hFF, 8'h00, 8'd100, 1'b0));
            else send_item(make_px(8'h00, 8'hFF, 8'd90, 1'b0));
        end
        for (int k = 0; k < 4; k++) begin
            if (k == 1) send_item(make_px(8'hFF, 8'hFF, 8'hFF, 1'b0));
            else send_item(make_px(8'h00, 8'h00, 8'h00, 1'b1));
        end

        // random part
        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            if (phase == 4 || phase == 9) begin
                if (phase == 4) run_wide_partial();
                else run_tall_partial();
            end else begin
                if (tracker.at_start() && $urandom_range(0, 99) < 35) new_small_dims();
                roll = $urandom_range(0, 99);
                if (roll < 70) send_frame(1'b0);
                else if (roll < 85) send_frame(1'b1);
                else send_broken_frame();
            end
            phase++;
        end

        // drain everything still queued, then settle once more
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending_pixels.size() != 0) begin
            $display("%0d results never arrived", tracker.pending_pixels.size());
            tracker.bad_pixels += tracker.pending_pixels.size();
        end

        $display("sent %0d pixel requests across %0d size register writes, %0d frames closed",
                 sent_items, dim_settings, tracker.frames_done);
        $display("checked %0d results, %0d bad, in %0d cycles",
                 tracker.good_pixels + tracker.bad_pixels, tracker.bad_pixels, cycle_count);
        if (tracker.bad_pixels == 0) begin
            $display("[laplacian_edge_filter_3x3_core] OK");
        end else begin
            $display("[laplacian_edge_filter_3x3_core] ERROR");
        end
        $finish;
    end

endmodule
